// File: hw/rtl/hbsg_pkg.sv
package hbsg_pkg;

  // Field and counter widths
  localparam int POS_W = 17;
  localparam int CNT_W = 18;
  localparam int SPM_W = 8;

  // Target fraction bits (1/2^POS_FRAC_BITS mm)
  localparam int POS_FRAC_BITS = 8;

  localparam logic [SPM_W-1:0] SPM_RESET = SPM_W'(80);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Request codes
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_MOVE = 1'b1
  } req_t;

  // Item handed from the input stage to the step core
  typedef struct packed {
    req_t             req;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
  } item_t;

  // Result fields as registered by the step core
  typedef struct packed {
    logic step_a;
    logic step_b;
    logic dir_a;
    logic dir_b;
    logic b_first;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

// File: hw/rtl/hbsg_ifs.sv
interface hbsg_in_if;
  import hbsg_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [POS_W-1:0] target_x;
  logic [POS_W-1:0] target_y;
  modport source(output valid, req_type, target_x, target_y, input ready);
  modport sink(input valid, req_type, target_x, target_y, output ready);
endinterface

interface hbsg_out_if;
  logic valid;
  logic ready;
  logic step_a;
  logic step_b;
  logic dir_a;
  logic dir_b;
  logic b_first;
  logic busy_res;
  logic rejected;
  modport source(output valid, step_a, step_b, dir_a, dir_b, b_first, busy_res, rejected,
                 input ready);
  modport sink(input valid, step_a, step_b, dir_a, dir_b, b_first, busy_res, rejected,
               output ready);
endinterface

interface hbsg_cfg_if;
  import hbsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [SPM_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: hw/rtl/hbsg_scale.sv
module hbsg_scale (
  input  logic            clk,
  input  logic            rst_n,
  hbsg_in_if.sink         in_ch,
  hbsg_cfg_if.sink        cfg_ch,
  output logic            item_valid,
  output hbsg_pkg::item_t item,
  input  logic            item_take
);
  import hbsg_pkg::*;

  localparam int PROD_W = POS_W + SPM_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'((1 << POS_FRAC_BITS) >> 1);

  logic [SPM_W-1:0] spm_r;
  logic             valid_r;
  item_t            item_r;
  item_t            item_nxt;

  // Round target * steps_per_mm / 2^frac, halves up, saturate
  function automatic logic [POS_W-1:0] to_steps(input logic [POS_W-1:0] t,
                                                input logic [SPM_W-1:0] spm);
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  s;
    prod = PROD_W'(t) * PROD_W'(spm);
    sum  = SUM_W'(prod) + HALF;
    s    = sum >> POS_FRAC_BITS;
    return (s > SUM_W'(POS_MAX)) ? POS_MAX : s[POS_W-1:0];
  endfunction

  // Config register, writable any time
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r <= SPM_RESET;
    end else if (cfg_ch.valid) begin
      spm_r <= cfg_ch.data;
    end
  end

  // Input register, scaled to steps on the way in
  assign in_ch.ready = !valid_r || item_take;

  always_comb begin
    item_nxt.req = req_t'(in_ch.req_type);
    item_nxt.tx  = to_steps(in_ch.target_x, spm_r);
    item_nxt.ty  = to_steps(in_ch.target_y, spm_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: hw/rtl/hbsg_core.sv
module hbsg_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  input  hbsg_pkg::item_t item,
  output logic            item_take,
  hbsg_out_if.source      out_ch
);
  import hbsg_pkg::*;

  localparam int DW = CNT_W + 1;

  // Motion state
  logic [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [CNT_W-1:0] major_left_r, major_left_nxt;
  logic [CNT_W-1:0] major_total_r, major_total_nxt;
  logic [CNT_W-1:0] minor_total_r, minor_total_nxt;
  logic [CNT_W-1:0] err_acc_r, err_acc_nxt;
  logic             a_major_r, a_major_nxt;
  logic [1:0]       dir_r, dir_nxt;

  logic             out_valid_r;
  res_t             res_r, res_nxt;

  logic signed [CNT_W-1:0] dx, dy;
  logic signed [DW-1:0]    da, db;
  logic [DW-1:0]           abs_a, abs_b;
  logic [CNT_W-1:0]        ma, mb;
  logic [CNT_W:0]          sum, sum_adj;
  logic                    minor_step;
  logic                    busy;
  logic                    a_ge_b;

  assign item_take = item_valid && (!out_valid_r || out_ch.ready);
  assign busy      = (major_left_r != '0);

  // Move setup: step deltas, motor deltas, magnitudes
  always_comb begin
    dx     = $signed({1'b0, item.tx}) - $signed({1'b0, pos_x_r});
    dy     = $signed({1'b0, item.ty}) - $signed({1'b0, pos_y_r});
    da     = $signed({dx[CNT_W-1], dx}) + $signed({dy[CNT_W-1], dy});
    db     = $signed({dx[CNT_W-1], dx}) - $signed({dy[CNT_W-1], dy});
    abs_a  = da[DW-1] ? DW'(-da) : DW'(da);
    abs_b  = db[DW-1] ? DW'(-db) : DW'(db);
    ma     = abs_a[CNT_W-1:0];
    mb     = abs_b[CNT_W-1:0];
    a_ge_b = (ma >= mb);
  end

  // Tick: Bresenham error update
  always_comb begin
    sum        = {1'b0, err_acc_r} + {1'b0, minor_total_r};
    minor_step = (sum >= {1'b0, major_total_r});
    sum_adj    = minor_step ? (sum - {1'b0, major_total_r}) : sum;
  end

  // Next state and result
  always_comb begin
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    major_left_nxt  = major_left_r;
    major_total_nxt = major_total_r;
    minor_total_nxt = minor_total_r;
    err_acc_nxt     = err_acc_r;
    a_major_nxt     = a_major_r;
    dir_nxt         = dir_r;
    res_nxt         = '0;
    unique case (item.req)
      REQ_MOVE: begin
        if (busy) begin
          res_nxt.rejected = 1'b1;
        end else begin
          dir_nxt[0]      = da[DW-1] || (da == '0);
          dir_nxt[1]      = db[DW-1] || (db == '0);
          a_major_nxt     = a_ge_b;
          major_total_nxt = a_ge_b ? ma : mb;
          minor_total_nxt = a_ge_b ? mb : ma;
          major_left_nxt  = a_ge_b ? ma : mb;
          err_acc_nxt     = '0;
          pos_x_nxt       = item.tx;
          pos_y_nxt       = item.ty;
        end
      end
      REQ_TICK: begin
        if (busy) begin
          err_acc_nxt    = sum_adj[CNT_W-1:0];
          major_left_nxt = major_left_r - CNT_W'(1);
          res_nxt.step_a = a_major_r ? 1'b1 : minor_step;
          res_nxt.step_b = a_major_r ? minor_step : 1'b1;
        end
      end
      default: ;
    endcase
    res_nxt.dir_a    = dir_nxt[0];
    res_nxt.dir_b    = dir_nxt[1];
    res_nxt.b_first  = !a_major_nxt;
    res_nxt.busy_res = (major_left_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      major_left_r  <= '0;
      major_total_r <= '0;
      minor_total_r <= '0;
      err_acc_r     <= '0;
      a_major_r     <= 1'b1;
      dir_r         <= '0;
    end else if (item_take) begin
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      major_left_r  <= major_left_nxt;
      major_total_r <= major_total_nxt;
      minor_total_r <= minor_total_nxt;
      err_acc_r     <= err_acc_nxt;
      a_major_r     <= a_major_nxt;
      dir_r         <= dir_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.step_a   = res_r.step_a;
  assign out_ch.step_b   = res_r.step_b;
  assign out_ch.dir_a    = res_r.dir_a;
  assign out_ch.dir_b    = res_r.dir_b;
  assign out_ch.b_first  = res_r.b_first;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.rejected = res_r.rejected;

`ifndef SYNTHESIS
  a_err_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (major_total_r != '0) |-> (err_acc_r < major_total_r))
    else $error("error accumulator reached major total");

  a_left_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    major_left_r <= major_total_r)
    else $error("major steps left exceed major total");

  a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
    minor_total_r <= major_total_r)
    else $error("minor total exceeds major total");

  a_tick_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.req == REQ_TICK && busy) |=>
      (major_left_r == $past(major_left_r) - CNT_W'(1)))
    else $error("tick did not consume one major step");

  a_reject_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.rejected) |-> (!res_r.step_a && !res_r.step_b))
    else $error("rejected move produced a step");
`endif

endmodule

// File: hw/rtl/hbot_step_pulse_generator_top.sv
// H-bot step generator: move targets set up a Bresenham run, ticks emit steps.
// An input transaction reaches its earliest result transaction through the input register,
// then the result register. Throughput: one transaction per cycle unless out_ch stalls;
// the state update is a single pass per item.
// Reset (rst_n, synchronous, active low): position, counters and error cleared,
// motor A major, directions 0, steps-per-mm register = 80. No clearing pass.
module hbot_step_pulse_generator_top (
  input  logic       clk,
  input  logic       rst_n,
  hbsg_in_if.sink    in_ch,
  hbsg_cfg_if.sink   cfg_ch,
  hbsg_out_if.source out_ch
);
  import hbsg_pkg::*;

  logic  item_valid;
  item_t item;
  logic  item_take;

  hbsg_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  hbsg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );

endmodule
